>>> sv/rve_pkg.sv
// Shared types and constants of the RISC execute stage.
`default_nettype none

package rve_pkg;

  localparam int unsigned DATA_W            = 32;
  localparam int unsigned PC_W              = 12;
  localparam int unsigned REG_IDX_W         = 4;
  localparam int unsigned REG_COUNT         = 16;
  localparam int unsigned IMM_W             = 12;
  localparam int unsigned SHAMT_W           = 5;
  localparam int unsigned ADDR_BITS_DEFAULT = 12;
  localparam logic [REG_IDX_W-1:0] LINK_REG = 4'd15;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_AND    = 4'd2,
    OP_OR     = 4'd3,
    OP_SLL    = 4'd4,
    OP_SRA    = 4'd5,
    OP_MAC    = 4'd6,
    OP_BRANCH = 4'd7,
    OP_JAL    = 4'd8,
    OP_LW     = 4'd9,
    OP_SW     = 4'd10,
    OP_JR     = 4'd11
  } op_e;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_GT = 4'd2,
    COND_LT = 4'd3,
    COND_GE = 4'd4,
    COND_LE = 4'd5
  } cond_e;

  typedef struct packed {
    logic [PC_W-1:0]      new_pc;
    logic                 pc_changed;
    logic                 reg_wr;
    logic [REG_IDX_W-1:0] widx;
    logic [DATA_W-1:0]    wval;
    logic                 is_load;
    logic                 is_store;
  } exec_res_t;

endpackage

`default_nettype wire

>>> sv/rve_alu.sv
// Execute datapath: arithmetic, shifts, multiply-add, branch compare and address generation.
`default_nettype none

module rve_alu import rve_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  op_e                   op_i,
  input  logic [REG_IDX_W-1:0]  rd_i,
  input  logic [REG_IDX_W-1:0]  cond_i,
  input  logic [DATA_W-1:0]     imm_i,
  input  logic [PC_W-1:0]       npc_i,
  input  logic [DATA_W-1:0]     a_i,
  input  logic [DATA_W-1:0]     b_i,
  input  logic [DATA_W-1:0]     m_i,
  input  logic [DATA_W-1:0]     d_i,
  output exec_res_t             res_o,
  output logic [ADDR_BITS-1:0]  mem_addr_o
);

  localparam logic [DATA_W-1:0] AddrMask = DATA_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic [DATA_W-1:0]  shift_sum;
  logic [SHAMT_W-1:0] shamt;
  logic [DATA_W-1:0]  addr_sum;
  logic [DATA_W-1:0]  prod;
  logic               taken;

  assign shift_sum = b_i + imm_i;
  assign shamt     = SHAMT_W'(shift_sum);
  assign addr_sum  = a_i + imm_i;
  assign prod      = a_i * b_i;

  always_comb begin
    case (cond_e'(cond_i))
      COND_EQ: taken = ($signed(a_i) == $signed(b_i));
      COND_NE: taken = ($signed(a_i) != $signed(b_i));
      COND_GT: taken = ($signed(a_i) >  $signed(b_i));
      COND_LT: taken = ($signed(a_i) <  $signed(b_i));
      COND_GE: taken = ($signed(a_i) >= $signed(b_i));
      COND_LE: taken = ($signed(a_i) <= $signed(b_i));
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    res_o            = '0;
    res_o.new_pc     = npc_i;
    mem_addr_o       = '0;
    case (op_i)
      OP_ADD: begin
        res_o.reg_wr = 1'b1;
        res_o.widx   = rd_i;
        res_o.wval   = a_i + b_i + imm_i;
      end
      OP_SUB: begin
        res_o.reg_wr = 1'b1;
        res_o.widx   = rd_i;
        res_o.wval   = a_i - b_i - imm_i;
      end
      OP_AND: begin
        res_o.reg_wr = 1'b1;
        res_o.widx   = rd_i;
        res_o.wval   = a_i & b_i & imm_i;
      end
      OP_OR: begin
        res_o.reg_wr = 1'b1;
        res_o.widx   = rd_i;
        res_o.wval   = a_i | b_i | imm_i;
      end
      OP_SLL: begin
        res_o.reg_wr = 1'b1;
        res_o.widx   = rd_i;
        res_o.wval   = a_i << shamt;
      end
      OP_SRA: begin
        res_o.reg_wr = 1'b1;
        res_o.widx   = rd_i;
        res_o.wval   = DATA_W'($signed(a_i) >>> shamt);
      end
      OP_MAC: begin
        res_o.reg_wr = 1'b1;
        res_o.widx   = rd_i;
        res_o.wval   = prod + m_i + imm_i;
      end
      OP_BRANCH: begin
        if (taken) begin
          res_o.new_pc     = PC_W'(imm_i & AddrMask);
          res_o.pc_changed = 1'b1;
        end
      end
      OP_JAL: begin
        res_o.reg_wr     = 1'b1;
        res_o.widx       = LINK_REG;
        res_o.wval       = DATA_W'(npc_i) & AddrMask;
        res_o.new_pc     = PC_W'(imm_i & AddrMask);
        res_o.pc_changed = 1'b1;
      end
      OP_LW: begin
        res_o.reg_wr  = 1'b1;
        res_o.widx    = rd_i;
        res_o.is_load = 1'b1;
        mem_addr_o    = ADDR_BITS'(addr_sum);
      end
      OP_SW: begin
        res_o.is_store = 1'b1;
        mem_addr_o     = ADDR_BITS'(addr_sum);
      end
      OP_JR: begin
        res_o.new_pc     = PC_W'(d_i & AddrMask);
        res_o.pc_changed = 1'b1;
      end
      default: begin
        res_o.new_pc = npc_i;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/risc_execute_stage_top.sv
// Top level of the RISC execute stage: request register, register file, data memory, result register.
//
//   channel  direction  handshake               payload
//   in       request    in_valid_i / in_stall_o  req_type_i .. next_pc_i
//   out      result     out_valid_o / out_stall_i new_pc_o .. mem_address_o
//
// One request per cycle unless output stalls; a result is registered after the request register.
// The register file is read from flops, with the load data forwarded until it is written there.
// Data memory is a single port array, read into a register as a load enters the result stage.
// Reset clears the register file and the valid flags at once; memory holds no reset.
// A stalled result also holds a full request register, which refills as soon as it drains.
`default_nettype none

module risc_execute_stage_top import rve_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [3:0]             req_type_i,
  input  logic [REG_IDX_W-1:0]   dest_reg_i,
  input  logic [REG_IDX_W-1:0]   src_reg_a_i,
  input  logic [REG_IDX_W-1:0]   src_reg_b_i,
  input  logic [REG_IDX_W-1:0]   extra_reg_i,
  input  logic signed [IMM_W-1:0] immediate_i,
  input  logic [PC_W-1:0]        next_pc_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [PC_W-1:0]        new_pc_o,
  output logic                   pc_changed_o,
  output logic                   reg_written_o,
  output logic [REG_IDX_W-1:0]   written_index_o,
  output logic signed [DATA_W-1:0] written_value_o,
  output logic                   store_done_o,
  output logic [PC_W-1:0]        mem_address_o
);

  localparam int unsigned MemDepth = 2 ** ADDR_BITS;

  logic                 e_valid_q;
  logic [3:0]           e_type_q;
  logic [REG_IDX_W-1:0] e_rd_q;
  logic [REG_IDX_W-1:0] e_rs_q;
  logic [REG_IDX_W-1:0] e_rt_q;
  logic [REG_IDX_W-1:0] e_rm_q;
  logic [DATA_W-1:0]    e_imm_q;
  logic [PC_W-1:0]      e_npc_q;

  logic                 w_valid_q;
  exec_res_t            w_res_q;
  logic [PC_W-1:0]      w_addr_q;

  logic [DATA_W-1:0]    rf_q [REG_COUNT];
  logic [DATA_W-1:0]    mem_q [MemDepth];
  logic [DATA_W-1:0]    mem_rdata_q;
  logic                 ld_pend_q;
  logic [REG_IDX_W-1:0] ld_idx_q;

  logic                 e_adv;
  logic                 in_accept;
  logic                 rf_wr;
  logic [DATA_W-1:0]    a_val;
  logic [DATA_W-1:0]    b_val;
  logic [DATA_W-1:0]    m_val;
  logic [DATA_W-1:0]    d_val;
  exec_res_t            res;
  logic [ADDR_BITS-1:0] mem_idx;

  assign e_adv      = e_valid_q && (!w_valid_q || !out_stall_i);
  assign in_stall_o = e_valid_q && !e_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign rf_wr      = e_adv && res.reg_wr && !res.is_load;

  // forward the load result until it reaches the register file
  assign a_val = (ld_pend_q && ld_idx_q == e_rs_q) ? mem_rdata_q : rf_q[e_rs_q];
  assign b_val = (ld_pend_q && ld_idx_q == e_rt_q) ? mem_rdata_q : rf_q[e_rt_q];
  assign m_val = (ld_pend_q && ld_idx_q == e_rm_q) ? mem_rdata_q : rf_q[e_rm_q];
  assign d_val = (ld_pend_q && ld_idx_q == e_rd_q) ? mem_rdata_q : rf_q[e_rd_q];

  rve_alu #(
    .ADDR_BITS (ADDR_BITS)
  ) u_alu (
    .op_i       (op_e'(e_type_q)),
    .rd_i       (e_rd_q),
    .cond_i     (e_rm_q),
    .imm_i      (e_imm_q),
    .npc_i      (e_npc_q),
    .a_i        (a_val),
    .b_i        (b_val),
    .m_i        (m_val),
    .d_i        (d_val),
    .res_o      (res),
    .mem_addr_o (mem_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (in_accept) begin
      e_valid_q <= 1'b1;
    end else if (e_adv) begin
      e_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      e_type_q <= req_type_i;
      e_rd_q   <= dest_reg_i;
      e_rs_q   <= src_reg_a_i;
      e_rt_q   <= src_reg_b_i;
      e_rm_q   <= extra_reg_i;
      e_imm_q  <= DATA_W'(immediate_i);
      e_npc_q  <= next_pc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      ld_pend_q <= 1'b0;
    end else begin
      ld_pend_q <= e_adv && res.is_load;
      if (e_adv) begin
        w_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        w_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_adv) begin
      w_res_q  <= res;
      w_addr_q <= PC_W'(mem_idx);
      ld_idx_q <= res.widx;
    end
  end

  // drop the pending load write when a newer result hits the same register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      if (ld_pend_q && !(rf_wr && res.widx == ld_idx_q)) begin
        rf_q[ld_idx_q] <= mem_rdata_q;
      end
      if (rf_wr) begin
        rf_q[res.widx] <= res.wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_adv && res.is_store) begin
      mem_q[mem_idx] <= d_val;
    end
    if (e_adv && res.is_load) begin
      mem_rdata_q <= mem_q[mem_idx];
    end
  end

  assign out_valid_o     = w_valid_q;
  assign new_pc_o        = w_res_q.new_pc;
  assign pc_changed_o    = w_res_q.pc_changed;
  assign reg_written_o   = w_res_q.reg_wr;
  assign written_index_o = w_res_q.widx;
  assign written_value_o = w_res_q.is_load ? mem_rdata_q : w_res_q.wval;
  assign store_done_o    = w_res_q.is_store;
  assign mem_address_o   = w_addr_q;

endmodule

`default_nettype wire

>>> sv/rve_checker.sv
// Port-level checks of the RISC execute stage and their binding to the top level.
`default_nettype none

module rve_checker import rve_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  logic [PC_W-1:0]        new_pc_o,
  input  logic                   pc_changed_o,
  input  logic                   reg_written_o,
  input  logic [REG_IDX_W-1:0]   written_index_o,
  input  logic signed [DATA_W-1:0] written_value_o,
  input  logic                   store_done_o,
  input  logic [PC_W-1:0]        mem_address_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(written_value_o)
      && $stable(new_pc_o) && $stable(mem_address_o))
    else $error("stalled result changed");

  a_store_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_done_o |-> !reg_written_o && !pc_changed_o)
    else $error("store also wrote a register or moved the pc");

  a_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pc_changed_o && reg_written_o |-> written_index_o == LINK_REG)
    else $error("redirect with write not to link register");

  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_written_o |-> written_index_o == '0 && written_value_o == '0)
    else $error("index or value set without a register write");

  a_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_address_o != '0 |-> store_done_o || (reg_written_o && !pc_changed_o))
    else $error("address set without a memory access");

endmodule

bind risc_execute_stage_top rve_checker u_rve_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .new_pc_o        (new_pc_o),
  .pc_changed_o    (pc_changed_o),
  .reg_written_o   (reg_written_o),
  .written_index_o (written_index_o),
  .written_value_o (written_value_o),
  .store_done_o    (store_done_o),
  .mem_address_o   (mem_address_o)
);

`default_nettype wire

>>> tb/tb_risc_execute_stage_top.sv
// Testbench of the RISC execute stage: directed and random instructions checked against a shadow core.
`timescale 1ns / 100ps

module tb_risc_execute_stage_top import rve_pkg::*; ;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  rd;
    logic [3:0]  rs;
    logic [3:0]  rt;
    logic [3:0]  rm;
    logic [11:0] imm;
    logic [11:0] npc;
  } instr_t;

  typedef struct packed {
    logic [11:0] new_pc;
    logic        pc_changed;
    logic        reg_written;
    logic [3:0]  widx;
    logic [31:0] wval;
    logic        store_done;
    logic [11:0] maddr;
  } effect_t;

  class shadow_core;
    logic [31:0] regs [16];
    logic [31:0] mem [logic [11:0]];
    logic [11:0] stored_addrs [$];
    effect_t     effects_due [$];
    int unsigned mismatches;
    int unsigned results;
    int unsigned retired;
    int unsigned loads;
    int unsigned stores;
    int unsigned redirects;
    int unsigned unused_ops;

    function new();
      foreach (regs[i]) regs[i] = '0;
      mismatches = 0;
      results    = 0;
      retired    = 0;
      loads      = 0;
      stores     = 0;
      redirects  = 0;
      unused_ops = 0;
    endfunction

    function void retire(instr_t r);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] imm32;
      logic [31:0] shift_sum;
      logic [31:0] addr_sum;
      bit          hit;
      effect_t     e;
      a         = regs[r.rs];
      b         = regs[r.rt];
      imm32     = {{20{r.imm[11]}}, r.imm};
      shift_sum = b + imm32;
      addr_sum  = a + imm32;
      hit       = 1'b0;
      e         = '0;
      e.new_pc  = r.npc;
      case (r.op)
        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLL, OP_SRA, OP_MAC: begin
          e.reg_written = 1'b1;
          e.widx        = r.rd;
          case (r.op)
            OP_ADD:  e.wval = a + b + imm32;
            OP_SUB:  e.wval = a - b - imm32;
            OP_AND:  e.wval = a & b & imm32;
            OP_OR:   e.wval = a | b | imm32;
            OP_SLL:  e.wval = a << shift_sum[4:0];
            OP_SRA:  e.wval = $signed(a) >>> shift_sum[4:0];
            default: e.wval = a * b + regs[r.rm] + imm32;
          endcase
        end
        OP_BRANCH: begin
          case (r.rm)
            COND_EQ: hit = (a == b);
            COND_NE: hit = (a != b);
            COND_GT: hit = ($signed(a) > $signed(b));
            COND_LT: hit = ($signed(a) < $signed(b));
            COND_GE: hit = ($signed(a) >= $signed(b));
            COND_LE: hit = ($signed(a) <= $signed(b));
            default: hit = 1'b0;
          endcase
          if (hit) begin
            e.new_pc     = imm32[11:0];
            e.pc_changed = 1'b1;
          end
        end
        OP_JAL: begin
          e.reg_written = 1'b1;
          e.widx        = LINK_REG;
          e.wval        = {20'd0, r.npc};
          e.new_pc      = imm32[11:0];
          e.pc_changed  = 1'b1;
        end
        OP_LW: begin
          e.maddr       = addr_sum[11:0];
          e.reg_written = 1'b1;
          e.widx        = r.rd;
          e.wval        = mem.exists(e.maddr) ? mem[e.maddr] : '0;
          loads++;
        end
        OP_SW: begin
          e.maddr      = addr_sum[11:0];
          e.store_done = 1'b1;
          if (!mem.exists(e.maddr)) stored_addrs.push_back(e.maddr);
          mem[e.maddr] = regs[r.rd];
          stores++;
        end
        OP_JR: begin
          e.new_pc     = regs[r.rd][11:0];
          e.pc_changed = 1'b1;
        end
        default: begin
          unused_ops++;
        end
      endcase
      if (e.reg_written) regs[e.widx] = e.wval;
      if (e.pc_changed) redirects++;
      retired++;
      effects_due.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < 40) begin
        $display("mismatch at result %0d: %s got %h want %h", results, what, got, want);
      end
      mismatches++;
    endtask

    task compare_effect(effect_t got);
      effect_t want;
      results++;
      if (effects_due.size() == 0) begin
        report("result with no request pending, new_pc", got.new_pc, '0);
        return;
      end
      want = effects_due.pop_front();
      if (got.new_pc !== want.new_pc) report("new_pc", got.new_pc, want.new_pc);
      if (got.pc_changed !== want.pc_changed) report("pc_changed", got.pc_changed, want.pc_changed);
      if (got.reg_written !== want.reg_written) begin
        report("reg_written", got.reg_written, want.reg_written);
      end
      if (got.widx !== want.widx) report("written_index", got.widx, want.widx);
      if (got.wval !== want.wval) report("written_value", got.wval, want.wval);
      if (got.store_done !== want.store_done) report("store_done", got.store_done, want.store_done);
      if (got.maddr !== want.maddr) report("mem_address", got.maddr, want.maddr);
    endtask
  endclass

  localparam int unsigned RANDOM_ITEMS = 1624;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam logic [3:0]  OP_UNUSED_LO = 4'd12;
  localparam logic [3:0]  OP_UNUSED_HI = 4'd15;
  localparam logic [3:0]  COND_NONE_LO = 4'd6;
  localparam logic [3:0]  COND_NONE_HI = 4'd15;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [3:0]               req_type_i  = '0;
  logic [REG_IDX_W-1:0]     dest_reg_i  = '0;
  logic [REG_IDX_W-1:0]     src_reg_a_i = '0;
  logic [REG_IDX_W-1:0]     src_reg_b_i = '0;
  logic [REG_IDX_W-1:0]     extra_reg_i = '0;
  logic signed [IMM_W-1:0]  immediate_i = '0;
  logic [PC_W-1:0]          next_pc_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [PC_W-1:0]          new_pc_o;
  logic                     pc_changed_o;
  logic                     reg_written_o;
  logic [REG_IDX_W-1:0]     written_index_o;
  logic signed [DATA_W-1:0] written_value_o;
  logic                     store_done_o;
  logic [PC_W-1:0]          mem_address_o;

  shadow_core  sb;
  int unsigned idle_cycles = 0;

  risc_execute_stage_top dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic int unsigned draw_wait(int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 14);
      default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  function automatic instr_t mk(logic [3:0] op, logic [3:0] rd, logic [3:0] rs,
                                logic [3:0] rt, logic [3:0] rm, int imm, int npc);
    instr_t r;
    r.op  = op;
    r.rd  = rd;
    r.rs  = rs;
    r.rt  = rt;
    r.rm  = rm;
    r.imm = imm[11:0];
    r.npc = npc[11:0];
    return r;
  endfunction

  function automatic instr_t random_instr();
    instr_t      r;
    int unsigned pick;
    logic [11:0] target;
    r.rd  = 4'($urandom_range(0, 15));
    r.rs  = 4'($urandom_range(0, 15));
    r.rt  = 4'($urandom_range(0, 15));
    r.rm  = 4'($urandom_range(0, 15));
    r.imm = 12'($urandom_range(0, 4095));
    r.npc = 12'($urandom_range(0, 4095));
    pick  = $urandom_range(0, 99);
    if (pick < 50) begin
      r.op = 4'($urandom_range(OP_ADD, OP_MAC));
    end else if (pick < 62) begin
      r.op = OP_BRANCH;
      if ($urandom_range(0, 4) != 0) r.rm = 4'($urandom_range(COND_EQ, COND_LE));
      if ($urandom_range(0, 2) == 0) r.rt = r.rs;
    end else if (pick < 67) begin
      r.op = OP_JAL;
    end else if (pick < 92) begin
      r.op = (pick < 78 && sb.stored_addrs.size() != 0) ? OP_LW : OP_SW;
      // steer loads, and some stores, onto words already written
      if (sb.stored_addrs.size() != 0 && (r.op == OP_LW || $urandom_range(0, 2) == 0)) begin
        target = sb.stored_addrs[$urandom_range(0, sb.stored_addrs.size() - 1)];
        r.imm  = target - sb.regs[r.rs][11:0];
      end
    end else if (pick < 97) begin
      r.op = OP_JR;
    end else begin
      r.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    return r;
  endfunction

  task automatic send(instr_t r, int unsigned mode);
    int unsigned gap;
    gap = draw_wait(mode);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= r.op;
    dest_reg_i  <= r.rd;
    src_reg_a_i <= r.rs;
    src_reg_b_i <= r.rt;
    extra_reg_i <= r.rm;
    immediate_i <= r.imm;
    next_pc_i   <= r.npc;
    do @(posedge clk_i); while (in_stall_o);
    sb.retire(r);
  endtask

  // result side: random stall lengths, with stretches of none
  initial begin
    effect_t     got;
    int unsigned w;
    int unsigned mode;
    int unsigned n;
    mode = 0;
    n    = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (n % 64 == 0) mode = $urandom_range(0, 2);
      w = draw_wait(mode);
      if (w != 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.new_pc      = new_pc_o;
      got.pc_changed  = pc_changed_o;
      got.reg_written = reg_written_o;
      got.widx        = written_index_o;
      got.wval        = written_value_o;
      got.store_done  = store_done_o;
      got.maddr       = mem_address_o;
      sb.compare_effect(got);
      n++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    instr_t      directed [$];
    int unsigned req_mode;
    sb = new();
    directed = '{
      mk(OP_ADD,       1,  0,  0,  0,            2047,  0),
      mk(OP_ADD,       2,  0,  0,  0,           -2048,  4095),
      mk(OP_OR,        4,  0,  0,  0,              -1,  1),
      mk(OP_SLL,       5,  4,  0,  0,              31,  2),
      mk(OP_SRA,       6,  5,  0,  0,              -1,  3),
      mk(OP_SRA,       7,  5,  1,  0,               1,  4),
      mk(OP_SUB,       8,  5,  0,  0,               1,  5),
      mk(OP_MAC,       9,  8,  8,  2,               5,  6),
      mk(OP_AND,      10,  4,  8,  0,              -1,  7),
      mk(OP_SUB,       3,  2,  1,  0,           -2048,  8),
      mk(OP_BRANCH,    0,  0,  0,  COND_EQ,         9,  9),
      mk(OP_BRANCH,    0,  8,  8,  COND_NE,       100,  10),
      mk(OP_BRANCH,    0,  8,  5,  COND_GT,        -1,  11),
      mk(OP_BRANCH,    0,  5,  8,  COND_LT,     -2048,  12),
      mk(OP_BRANCH,    0,  5,  5,  COND_GE,      2047,  13),
      mk(OP_BRANCH,    0,  8,  5,  COND_LE,         0,  14),
      mk(OP_BRANCH,    0,  0,  0,  COND_NONE_LO,    1,  15),
      mk(OP_BRANCH,    0,  0,  0,  COND_NONE_HI,    1,  16),
      mk(OP_JAL,       0,  0,  0,  0,           -2048,  4095),
      mk(OP_SW,        8,  4,  0,  0,               0,  17),
      mk(OP_LW,       11,  0,  0,  0,              -1,  18),
      mk(OP_SW,        5,  0,  0,  0,               0,  19),
      mk(OP_LW,       15,  1,  0,  0,           -2047,  20),
      mk(OP_JR,        4,  0,  0,  0,               0,  21),
      mk(OP_UNUSED_LO, 15, 15, 15, 15,             -1,  4095),
      mk(OP_UNUSED_HI, 15, 15, 15, 15,             -1,  4095)
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send(directed[i], 1);
    req_mode = 0;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) req_mode = $urandom_range(0, 2);
      send(random_instr(), req_mode);
    end
    in_valid_i <= 1'b0;
    while (sb.effects_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d instructions retired (%0d directed), %0d results compared",
             sb.retired, directed.size(), sb.results);
    $display("%0d loads, %0d stores, %0d pc redirects, %0d unused opcodes, %0d mismatches",
             sb.loads, sb.stores, sb.redirects, sb.unused_ops, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
